>>> hw/rtl/accel_tilt_angles_assert.svh
// Assertion macros for the tilt-angle block
`ifndef ACCEL_TILT_ANGLES_ASSERT_SVH
`define ACCEL_TILT_ANGLES_ASSERT_SVH
`define ATA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ATA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hw/rtl/ata_pkg.sv
`default_nettype none
package ata_pkg;
  localparam int CORDIC_STAGES_DEF   = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int TABLE_FRAC = 30;
  localparam int CW = 56;   // CORDIC datapath width
  localparam int ZW = 34;   // angle accumulator width, Q30
  localparam logic [1:0] SENS_2G = 2'd2;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] t;
    case (i)
      0: t = 34'sd843314857;  1: t = 34'sd497837829;
      2: t = 34'sd263043837;  3: t = 34'sd133525159;
      4: t = 34'sd67021687;   5: t = 34'sd33543516;
      6: t = 34'sd16775851;   7: t = 34'sd8388437;
      8: t = 34'sd4194283;    9: t = 34'sd2097149;
      default: t = 34'sd1 <<< (30 - i);
    endcase
    return t;
  endfunction

  // half pi at the output resolution, rounded half up
  function automatic longint half_pi_q(input int fb);
    return (HALF_PI_Q30 + (64'sd1 <<< (TABLE_FRAC - fb - 1))) >>> (TABLE_FRAC - fb);
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/ata_isqrt.sv
`default_nettype none
// Pipelined square root of (b*b+c*c) << 32; one result bit per stage, 33 stages.
module ata_isqrt import ata_pkg::*; (
  input  wire logic        clk,
  input  wire logic [31:0] sq,
  output logic      [32:0] root
);
  localparam int N = 33;
  logic [65:0] rem [N+1];
  logic [32:0] res [N+1];
  logic [31:0] sqd [N+1];
  always_comb begin
    rem[0] = '0;
    res[0] = '0;
    sqd[0] = sq;
  end
  for (genvar k = 0; k < N; k++) begin : g_st
    logic [65:0] rad, trial;
    logic [1:0] pair;
    // radicand {2'b00, sq, 32'b0} taken two bits a stage from the top
    if (k >= 1 && k <= 16) begin : g_sq
      assign pair = sqd[k][33-2*k -: 2];
    end else begin : g_pad
      assign pair = 2'b00;
    end
    always_comb begin
      rad   = {rem[k][63:0], pair};
      trial = {31'b0, res[k], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rad >= trial) begin
        rem[k+1] <= rad - trial;
        res[k+1] <= {res[k][31:0], 1'b1};
      end else begin
        rem[k+1] <= rad;
        res[k+1] <= {res[k][31:0], 1'b0};
      end
      sqd[k+1] <= sqd[k];
    end
  end
  assign root = res[N];
endmodule
`default_nettype wire

>>> hw/rtl/ata_lane.sv
`default_nettype none
// One tilt lane: square root pipeline then vectoring CORDIC, fixed latency.
module ata_lane import ata_pkg::*; #(
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic signed [15:0] a,
  input  wire logic signed [15:0] b,
  input  wire logic signed [15:0] c,
  output logic signed [ZW-1:0]    angle
);
  localparam int SQD = 34;  // 1 + 33 root stages
  localparam longint HALF = half_pi_q(ANGLE_FRAC_BITS);
  localparam int S = TABLE_FRAC - ANGLE_FRAC_BITS;

  logic [31:0] sq;
  logic [32:0] root;
  logic signed [15:0] ad [SQD];
  logic zb [SQD];
  always_ff @(posedge clk) begin
    sq    <= 32'(b * b) + 32'(c * c);
    ad[0] <= a;
    zb[0] <= (b == 0) && (c == 0);
    for (int k = 1; k < SQD; k++) begin
      ad[k] <= ad[k-1];
      zb[k] <= zb[k-1];
    end
  end
  ata_isqrt u_sqrt (.clk(clk), .sq(sq), .root(root));

  logic signed [CW-1:0] x [CORDIC_STAGES+1];
  logic signed [CW-1:0] y [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z [CORDIC_STAGES+1];
  logic sa [CORDIC_STAGES+1];
  logic zc [CORDIC_STAGES+1];
  always_comb begin
    x[0]  = CW'(signed'({1'b0, root}));
    y[0]  = CW'(ad[SQD-1]) <<< 16;
    z[0]  = '0;
    sa[0] = ad[SQD-1][15];
    zc[0] = zb[SQD-1];
  end
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cor
    always_ff @(posedge clk) begin
      if (!y[i][CW-1]) begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + atan_q30(i);
      end else begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - atan_q30(i);
      end
      sa[i+1] <= sa[i];
      zc[i+1] <= zc[i];
    end
  end

  logic signed [ZW-1:0] q;
  always_comb begin
    q = (z[CORDIC_STAGES] + (ZW'(1) <<< (S - 1))) >>> S;
    if (zc[CORDIC_STAGES]) q = sa[CORDIC_STAGES] ? -ZW'(HALF) : ZW'(HALF);
    else if (q > ZW'(HALF)) q = ZW'(HALF);
    else if (q < -ZW'(HALF)) q = -ZW'(HALF);
  end
  always_ff @(posedge clk) angle <= q;
endmodule
`default_nettype wire

>>> hw/rtl/accel_tilt_angles.sv
`default_nettype none
// Tilt-angle unit for a three-axis accelerometer.
// s_axis: one beat per sample; tdata = {sample_z, sample_y, sample_x}.
// m_axis: one beat per sample with the scaled axes and three tilt angles.
// cfg_we/cfg_wdata write the range select (sensitivity); the user must do so
// while idle; the block does not enforce it. Throughput: one beat per cycle
// while credit lasts. To m_axis_tvalid a beat passes the squares, 33-step root
// pipeline, CORDIC stages, clamp, skid buffer write and skid buffer read register.
// Three lanes run side by side, one per axis; a merge stage adds the z
// offset and forms the output beat.
// Stall: the lanes never stop; a credit count keeps the beats in flight
// within the skid buffer, so a stalled receiver fills it, the output beat
// is held and s_axis_tready drops once the credit is used up.
// Reset clears valid flags and sets the 2g range; results in flight are lost.
module accel_tilt_angles import ata_pkg::*; #(
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_wdata,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [47:0]  s_axis_tdata,  // sample_x, sample_y, sample_z
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // accel_x_g, accel_y_g, accel_z_g (18 each), angle_x, angle_y (15), angle_z (16)
  output logic [103:0]      m_axis_tdata
);
  localparam int LAT = CORDIC_STAGES + 36;
  localparam longint HALF = half_pi_q(ANGLE_FRAC_BITS);

  logic [1:0] sensitivity;
  always_ff @(posedge clk) begin
    if (rst) sensitivity <= SENS_2G;
    else if (cfg_we) sensitivity <= cfg_wdata;
  end

  // Lanes run freely; a credit counter keeps in-flight beats within a skid
  // buffer of LAT+2 entries so nothing is lost on stall.
  localparam int FD = LAT + 2;
  localparam int AW = $clog2(FD);
  logic [AW:0] credit;
  logic [LAT-2:0] vpipe;
  logic fire_in;
  assign s_axis_tready = (credit < (AW+1)'(FD));
  assign fire_in = s_axis_tvalid && s_axis_tready;

  logic signed [15:0] sx, sy, sz;
  assign sx = s_axis_tdata[15:0];
  assign sy = s_axis_tdata[31:16];
  assign sz = s_axis_tdata[47:32];

  logic [1:0] sens_eff;
  assign sens_eff = (sensitivity > SENS_2G) ? SENS_2G : sensitivity;
  logic [53:0] gpipe [LAT-1];
  always_ff @(posedge clk) begin
    gpipe[0] <= {18'(sz) <<< (2'd2 - sens_eff), 18'(sy) <<< (2'd2 - sens_eff),
                 18'(sx) <<< (2'd2 - sens_eff)};
    for (int k = 1; k < LAT-1; k++) gpipe[k] <= gpipe[k-1];
  end
  logic zneg [LAT-1];
  always_ff @(posedge clk) begin
    zneg[0] <= sz[15];
    for (int k = 1; k < LAT-1; k++) zneg[k] <= zneg[k-1];
  end

  logic signed [ZW-1:0] ax, ay, az;
  ata_lane #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS))
    u_lx (.clk(clk), .a(sx), .b(sy), .c(sz), .angle(ax));
  ata_lane #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS))
    u_ly (.clk(clk), .a(sy), .b(sz), .c(sx), .angle(ay));
  ata_lane #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS))
    u_lz (.clk(clk), .a(sz), .b(sx), .c(sy), .angle(az));

  // merge: z offset and packing (lane output aligns with stage LAT-2)
  logic signed [ZW-1:0] azo;
  logic [103:0] beat;
  assign azo = zneg[LAT-2] ? az + ZW'(HALF) : az - ZW'(HALF);
  assign beat = {4'b0000, azo[15:0], ay[14:0], ax[14:0], gpipe[LAT-2]};

  // skid buffer with a registered read port that doubles as the output beat
  logic [103:0] fifo [FD];
  logic [103:0] rdata;
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic ov;
  logic push, pop, rd_en;
  assign push  = vpipe[LAT-2];
  assign pop   = m_axis_tvalid && m_axis_tready;
  assign rd_en = (cnt != '0) && (!ov || pop);
  assign m_axis_tvalid = ov;
  assign m_axis_tdata  = rdata;

  always_ff @(posedge clk) begin
    if (push) fifo[wp] <= beat;
    if (rd_en) rdata <= fifo[rp];
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0; wp <= '0; rp <= '0; cnt <= '0; credit <= '0; ov <= 1'b0;
    end else begin
      vpipe <= {vpipe[LAT-3:0], fire_in};
      if (push)  wp <= (wp == AW'(FD-1)) ? '0 : wp + 1'b1;
      if (rd_en) rp <= (rp == AW'(FD-1)) ? '0 : rp + 1'b1;
      if (rd_en) ov <= 1'b1;
      else if (pop) ov <= 1'b0;
      cnt    <= cnt + (AW+1)'(push) - (AW+1)'(rd_en);
      credit <= credit + (AW+1)'(fire_in) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/ata_checker.sv
`default_nettype none
`include "accel_tilt_angles_assert.svh"
module ata_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [103:0] m_axis_tdata
);
  `ATA_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ATA_ASSERT_NEXT(a_data_hold, clk, rst, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `ATA_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_axis_tvalid)
  `ATA_ASSERT_IMPL(a_angle_x_range, clk, rst, m_axis_tvalid,
    $signed(m_axis_tdata[68:54]) <= 15'sd12868 && $signed(m_axis_tdata[68:54]) >= -15'sd12868)
endmodule
bind accel_tilt_angles ata_checker u_chk (.*);
`default_nettype wire

>>> test/accel_tilt_angles_checker.sv
`timescale 1ns / 1ps
module accel_tilt_angles_checker import ata_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_wdata,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,   // sample_x, sample_y, sample_z
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // accel_x_g, accel_y_g, accel_z_g, angle_x, angle_y, angle_z
  input  logic [103:0] m_axis_tdata,
  output int           fail_count,
  output int           outstanding
);

  localparam int FRAC = 13;
  localparam int STAGES = 16;

  typedef struct packed {
    logic [17:0] gx;
    logic [17:0] gy;
    logic [17:0] gz;
    logic [14:0] ang_x;
    logic [14:0] ang_y;
    logic [15:0] ang_z;
  } tilt_beat_t;

  tilt_beat_t tilt_q[$];
  logic [1:0] range_sel;

  longint arctan_q30 [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

  function automatic longint round_q30(longint z);
    return (z + (64'sd1 <<< (TABLE_FRAC - FRAC - 1))) >>> (TABLE_FRAC - FRAC);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint tilt_of(longint a, longint b, longint c);
    longint half_q, x, y, z, dx, dy, q;
    logic [63:0] mag_sq;
    half_q = round_q30(HALF_PI_Q30);
    if (b == 0 && c == 0) return (a >= 0) ? half_q : -half_q;
    mag_sq = 64'(b * b) + 64'(c * c);
    x = longint'(int_sqrt(mag_sq << 32));
    y = a * 65536;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += arctan_q30[i];
      end else begin
        x -= dx; y += dy; z -= arctan_q30[i];
      end
    end
    q = round_q30(z);
    if (q > half_q) q = half_q;
    if (q < -half_q) q = -half_q;
    return q;
  endfunction

  function automatic tilt_beat_t predict_tilt(logic [47:0] raw, logic [1:0] rsel);
    tilt_beat_t r;
    longint ax [3];
    longint half_q, az;
    int sh;
    sh = 2 - ((rsel > 2'd2) ? 2 : int'(rsel));
    for (int j = 0; j < 3; j++) ax[j] = longint'($signed(raw[16*j +: 16]));
    r.gx = 18'(ax[0] <<< sh);
    r.gy = 18'(ax[1] <<< sh);
    r.gz = 18'(ax[2] <<< sh);
    r.ang_x = 15'(tilt_of(ax[0], ax[1], ax[2]));
    r.ang_y = 15'(tilt_of(ax[1], ax[2], ax[0]));
    half_q = round_q30(HALF_PI_Q30);
    az = tilt_of(ax[2], ax[0], ax[1]);
    az = (ax[2] < 0) ? az + half_q : az - half_q;
    r.ang_z = 16'(az);
    return r;
  endfunction

  always @(posedge clk) begin
    tilt_beat_t exp_b;
    tilt_beat_t got;
    if (rst) begin
      range_sel = SENS_2G;
      fail_count = 0;
      tilt_q.delete();
    end else begin
      // a beat taken on the write edge still sees the old range
      if (s_axis_tvalid && s_axis_tready)
        tilt_q.push_back(predict_tilt(s_axis_tdata, range_sel));
      if (cfg_we) range_sel = cfg_wdata;
      if (m_axis_tvalid && m_axis_tready) begin
        got.gx = m_axis_tdata[17:0];
        got.gy = m_axis_tdata[35:18];
        got.gz = m_axis_tdata[53:36];
        got.ang_x = m_axis_tdata[68:54];
        got.ang_y = m_axis_tdata[83:69];
        got.ang_z = m_axis_tdata[99:84];
        if (tilt_q.size() == 0) begin
          $error("unexpected output beat %h", m_axis_tdata);
          fail_count++;
        end else begin
          exp_b = tilt_q.pop_front();
          if (got.gx !== exp_b.gx) begin
            $error("accel_x_g: expected %h got %h", exp_b.gx, got.gx); fail_count++;
          end
          if (got.gy !== exp_b.gy) begin
            $error("accel_y_g: expected %h got %h", exp_b.gy, got.gy); fail_count++;
          end
          if (got.gz !== exp_b.gz) begin
            $error("accel_z_g: expected %h got %h", exp_b.gz, got.gz); fail_count++;
          end
          if (got.ang_x !== exp_b.ang_x) begin
            $error("angle_x: expected %h got %h", exp_b.ang_x, got.ang_x); fail_count++;
          end
          if (got.ang_y !== exp_b.ang_y) begin
            $error("angle_y: expected %h got %h", exp_b.ang_y, got.ang_y); fail_count++;
          end
          if (got.ang_z !== exp_b.ang_z) begin
            $error("angle_z: expected %h got %h", exp_b.ang_z, got.ang_z); fail_count++;
          end
        end
      end
    end
    outstanding = tilt_q.size();
  end

endmodule

>>> test/tb_accel_tilt_angles.sv
`timescale 1ns / 1ps
module tb_accel_tilt_angles;
  import ata_pkg::*;

  localparam int SETTLE = 80;
  localparam int CYCLE_LIMIT = 400000;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [1:0]   cfg_wdata;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  int           fail_count;
  int           outstanding;
  int           cycles = 0;
  int           burst_left;
  int           stall_mode = 0;

  accel_tilt_angles uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  accel_tilt_angles_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_accel_tilt_angles failed");
      $finish;
    end
  end

  // receiver: switch stall pattern now and then
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= int'($urandom_range(0, 2));
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  function automatic logic [15:0] rand_axis();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      1: return 16'(int'($urandom_range(0, 8)) - 4);
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_sample(logic [15:0] sx, logic [15:0] sy, logic [15:0] sz);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = int'($urandom_range(1, 20));
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {sz, sy, sx};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // drain everything, let the pipeline empty, then write the range select
  task automatic set_range(logic [1:0] rsel);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= rsel;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  logic [1:0] ranges [4] = '{2'd0, 2'd1, 2'd3, SENS_2G};

  initial begin
    rst = 1'b1;
    burst_left = 0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // both other axes zero, all zero, extremes
    send_sample(16'h0000, 16'h0000, 16'h0000);
    send_sample(16'h7fff, 16'h0000, 16'h0000);
    send_sample(16'h8000, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h7fff, 16'h8000);
    send_sample(16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff);
    send_sample(16'h0001, 16'h0000, 16'h0000);
    send_sample(16'hffff, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h0000, 16'hffff);
    send_sample(16'h0000, 16'h0000, 16'h0005);
    send_sample(16'h0000, 16'h0003, 16'h0000);
    send_sample(16'h0064, 16'hff38, 16'h012c);
    send_sample(16'hffff, 16'hffff, 16'hffff);
    send_sample(16'h7fff, 16'h8000, 16'h0001);
    send_sample(16'h8000, 16'h7fff, 16'h0000);

    foreach (ranges[k]) begin
      set_range(ranges[k]);
      for (int n = 0; n < 360; n++) send_sample(rand_axis(), rand_axis(), rand_axis());
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_accel_tilt_angles passed");
    end else begin
      $display("tb_accel_tilt_angles failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ata_pkg.sv
hw/rtl/ata_isqrt.sv
hw/rtl/ata_lane.sv
hw/rtl/accel_tilt_angles.sv
hw/rtl/ata_checker.sv
test/accel_tilt_angles_checker.sv
test/tb_accel_tilt_angles.sv
